[rtl/stad_pkg.sv]
// ----------------------------------------------------------------------------
// stad_pkg
// Shared types and constants of the stepper axis step generator.
// ----------------------------------------------------------------------------
package stad_pkg;

	localparam int POSITION_BITS = 32;
	localparam int DIFF_W = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 1;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 20;

	localparam int S_TDATA_W = 112;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 72;

	localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;
	localparam logic signed [35:0] ERR_MAX = 36'sd8589934591;

	typedef enum logic [2:0] {
		KIND_SET_TARGET  = 3'd0,
		KIND_START_MOVE  = 3'd1,
		KIND_SET_STEPS   = 3'd2,
		KIND_TICK_ON     = 3'd3,
		KIND_TICK_OFF    = 3'd4,
		KIND_START_HOME  = 3'd5,
		KIND_HOME_TICK   = 3'd6
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_INVERSE_DIR     = 2'd0,
		REG_HOME_DIR        = 2'd1,
		REG_HOME_STEP_DELAY = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic               home_switch;
		logic [15:0]        elapsed;
		logic [30:0]        major_steps;
		logic               move_dir;
		logic [30:0]        step_count;
		logic signed [31:0] target_position;
	} in_beat_t;

	typedef struct packed {
		logic [5:0]         pad;
		logic               homed;
		logic [30:0]        steps_to_do;
		logic signed [31:0] position_now;
		logic               dir_level;
		logic               step_level;
	} out_beat_t;

endpackage

[rtl/stepper_axis_dda_with_homing.sv]
// ----------------------------------------------------------------------------
// stepper_axis_dda_with_homing
// One stepper axis: Bresenham step generation, target tracking and homing.
// ----------------------------------------------------------------------------
// Commands enter on s_axis (kind in tuser, operands in tdata); every command
// beat yields exactly one status beat on m_axis, in order.
// A beat is captured in an input register, the next axis state and the status
// word are formed in one pass of adders and compares, and both are stored
// together in the axis state and result registers, which also raise m_axis_tvalid.
// Throughput is one beat per cycle while m_axis takes each status beat; the
// position and error accumulators feed back into themselves through that one pass.
// The cfg channel writes inverse_dir, home_dir and home_step_delay; cfg_ready
// is always high and writes are meant for idle periods only.
// arst_n clears all axis state, the configuration registers and both valid flags at once.
// When m_axis stalls, the status beat holds; one more command waits in the
// input register, then s_axis_tready drops until the status beat is taken.
// ----------------------------------------------------------------------------
module stepper_axis_dda_with_homing (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// target_position[31:0], step_count[62:32], move_dir[63],
	// major_steps[94:64], elapsed[110:95], home_switch[111]
	input  logic [stad_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// kind[2:0]
	input  logic [stad_pkg::S_TUSER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// step_level[0], dir_level[1], position_now[33:2], steps_to_do[64:34],
	// homed[65], zero[71:66]
	output logic [stad_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [stad_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [stad_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int PB = stad_pkg::POSITION_BITS;
	localparam int DW = stad_pkg::DIFF_W;

	logic                     valid_s1;
	stad_pkg::in_beat_t       beat_s1;
	logic [stad_pkg::S_TUSER_W-1:0] s_axis_tuser_s1;
	stad_pkg::kind_t          kind_s1;
	logic                     advance;

	logic                     inverse_dir_q;
	logic                     home_dir_q;
	logic [19:0]              home_step_delay_q;

	logic signed [PB-1:0]     position_q, position_d;
	logic                     direction_q, direction_d;
	logic                     dir_out_q, dir_out_d;
	logic                     step_out_q, step_out_d;
	logic [30:0]              pending_q, pending_d;
	logic [30:0]              major_q, major_d;
	logic [30:0]              minor_q, minor_d;
	logic signed [33:0]       err_q, err_d;
	logic                     home_found_q, home_found_d;
	logic [31:0]              home_timer_q, home_timer_d;
	logic                     home_phase_q, home_phase_d;

	logic                     out_valid_q;
	stad_pkg::out_beat_t      out_q, out_d;

	logic signed [DW-1:0]     diff;
	logic [DW-1:0]            diff_mag;
	logic [30:0]              diff_sat;
	logic signed [PB-1:0]     pos_step;
	logic [30:0]              load_minor;
	logic signed [33:0]       err_load;
	logic signed [35:0]       err_delta;
	logic signed [35:0]       err_sum;
	logic [32:0]              timer_sum;
	logic [31:0]              timer_sat;
	logic signed [63:0]       pos_wide;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign kind_s1       = stad_pkg::kind_t'(s_axis_tuser_s1);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			beat_s1         <= stad_pkg::in_beat_t'(s_axis_tdata);
			s_axis_tuser_s1 <= s_axis_tuser;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_dir_q     <= 1'b0;
			home_dir_q        <= 1'b0;
			home_step_delay_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				stad_pkg::REG_INVERSE_DIR:     inverse_dir_q     <= cfg_data[0];
				stad_pkg::REG_HOME_DIR:        home_dir_q        <= cfg_data[0];
				stad_pkg::REG_HOME_STEP_DELAY: home_step_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// shared arithmetic
	always_comb begin
		diff      = DW'(beat_s1.target_position) - DW'(position_q);
		diff_mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
		diff_sat  = (diff_mag > DW'(stad_pkg::SAT31)) ? stad_pkg::SAT31 : diff_mag[30:0];
		pos_step  = direction_q ? PB'(position_q + PB'(1)) : PB'(position_q - PB'(1));
		load_minor = (kind_s1 == stad_pkg::KIND_START_MOVE) ? pending_q : beat_s1.step_count;
		err_load  = $signed({3'b000, load_minor}) - $signed({3'b000, beat_s1.major_steps});
		if (err_q[33]) begin
			err_delta = $signed({4'b0000, minor_q, 1'b0});
		end else begin
			err_delta = $signed({4'b0000, minor_q, 1'b0}) - $signed({4'b0000, major_q, 1'b0});
		end
		err_sum   = 36'(err_q) + err_delta;
		timer_sum = {1'b0, home_timer_q} + 33'(beat_s1.elapsed);
		timer_sat = timer_sum[32] ? 32'hFFFF_FFFF : timer_sum[31:0];
	end

	// next axis state
	always_comb begin
		position_d   = position_q;
		direction_d  = direction_q;
		dir_out_d    = dir_out_q;
		step_out_d   = step_out_q;
		pending_d    = pending_q;
		major_d      = major_q;
		minor_d      = minor_q;
		err_d        = err_q;
		home_found_d = home_found_q;
		home_timer_d = home_timer_q;
		home_phase_d = home_phase_q;
		case (kind_s1)
			stad_pkg::KIND_SET_TARGET: begin
				direction_d = !diff[DW-1];
				pending_d   = diff_sat;
			end
			stad_pkg::KIND_START_MOVE, stad_pkg::KIND_SET_STEPS: begin
				if (kind_s1 == stad_pkg::KIND_START_MOVE) begin
					dir_out_d = direction_q ^ inverse_dir_q;
				end else begin
					direction_d = beat_s1.move_dir;
					dir_out_d   = beat_s1.move_dir;
				end
				minor_d    = load_minor;
				major_d    = beat_s1.major_steps;
				err_d      = err_load;
				step_out_d = 1'b0;
			end
			stad_pkg::KIND_TICK_ON: begin
				if (!err_q[33]) begin
					step_out_d = 1'b1;
					position_d = pos_step;
				end
				err_d = (err_sum > stad_pkg::ERR_MAX) ? stad_pkg::ERR_MAX[33:0] : err_sum[33:0];
			end
			stad_pkg::KIND_TICK_OFF: begin
				step_out_d = 1'b0;
			end
			stad_pkg::KIND_START_HOME: begin
				if (beat_s1.home_switch) begin
					home_found_d = 1'b1;
				end else begin
					home_timer_d = '0;
					home_found_d = 1'b0;
					dir_out_d    = home_dir_q;
					home_phase_d = 1'b0;
				end
			end
			stad_pkg::KIND_HOME_TICK: begin
				if (!home_found_q) begin
					home_timer_d = timer_sat;
					if (timer_sat > 32'(home_step_delay_q)) begin
						home_timer_d = timer_sat - 32'(home_step_delay_q);
						if (home_phase_q) begin
							step_out_d = 1'b1;
						end else begin
							step_out_d = 1'b0;
							if (beat_s1.home_switch) begin
								home_found_d = 1'b1;
							end
						end
						home_phase_d = !home_phase_q;
					end
				end
			end
			default: ;
		endcase
	end

	// status word
	always_comb begin
		pos_wide           = 64'(position_d);
		out_d              = '0;
		out_d.step_level   = step_out_d;
		out_d.dir_level    = dir_out_d;
		out_d.position_now = pos_wide[31:0];
		out_d.steps_to_do  = pending_d;
		out_d.homed        = home_found_d;
	end

	// axis state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q   <= '0;
			direction_q  <= 1'b0;
			dir_out_q    <= 1'b0;
			step_out_q   <= 1'b0;
			pending_q    <= '0;
			major_q      <= '0;
			minor_q      <= '0;
			err_q        <= '0;
			home_found_q <= 1'b0;
			home_timer_q <= '0;
			home_phase_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				position_q   <= position_d;
				direction_q  <= direction_d;
				dir_out_q    <= dir_out_d;
				step_out_q   <= step_out_d;
				pending_q    <= pending_d;
				major_q      <= major_d;
				minor_q      <= minor_d;
				err_q        <= err_d;
				home_found_q <= home_found_d;
				home_timer_q <= home_timer_d;
				home_phase_q <= home_phase_d;
				out_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= out_d;
		end
	end

endmodule

[rtl/stad_checker.sv]
// ----------------------------------------------------------------------------
// stad_checker
// Port-level checks of the stepper axis step generator.
// ----------------------------------------------------------------------------
module stad_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [stad_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

	logic m_beat;
	assign m_beat = m_axis_tvalid && m_axis_tready;

	// hold a stalled status beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("status beat changed while stalled");

	// backpressure only from a full, stalled output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// advance position by at most one step per command
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_beat && $past(m_beat) |->
			m_axis_tdata[33:2] == $past(m_axis_tdata[33:2]) ||
			m_axis_tdata[33:2] == 32'($past(m_axis_tdata[33:2]) + 32'd1) ||
			m_axis_tdata[33:2] == 32'($past(m_axis_tdata[33:2]) - 32'd1))
		else $error("position jumped by more than one step");

	// drop tready never while empty
	a_no_beat_no_rdy_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind stepper_axis_dda_with_homing stad_checker u_stad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[tb/stepper_axis_dda_with_homing_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_axis_dda_with_homing_tb
// Self-checking bench for the stepper axis: commands stream in on s_axis,
// a cycle-free model of the axis state predicts each status beat, and the
// monitor checks every m_axis beat field by field. Both sides idle at random;
// the config channel changes registers only while the axis is idle.
// ----------------------------------------------------------------------------
module stepper_axis_dda_with_homing_tb;

	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [2:0]         kind;
		stad_pkg::in_beat_t ops;
	} command_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [stad_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [stad_pkg::S_TUSER_W-1:0]   s_axis_tuser = '0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [stad_pkg::M_TDATA_W-1:0]   m_axis_tdata;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [stad_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [stad_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// axis model: configuration copy
	logic                             cfg_inverse_dir = 1'b0;
	logic                             cfg_home_dir = 1'b0;
	logic [stad_pkg::CFG_DATA_W-1:0]  cfg_home_delay = '0;

	// axis model: state
	logic signed [stad_pkg::POSITION_BITS-1:0] ax_position = '0;
	logic                   ax_direction = 1'b0;
	logic                   ax_dir_out = 1'b0;
	logic                   ax_step_out = 1'b0;
	logic [30:0]            ax_pending = '0;
	longint                 ax_major = 0;
	longint                 ax_minor = 0;
	longint                 ax_error = 0;
	logic                   ax_home_found = 1'b0;
	logic [31:0]            ax_home_timer = '0;
	logic                   ax_home_phase = 1'b0;

	command_t            cmd_queue[$];
	stad_pkg::out_beat_t status_queue[$];
	command_t            cmd_now;
	int        queued_items = 0;
	int        src_gap = 0;
	int        sink_gap = 0;
	int        sink_wait;
	bit        src_busy;
	bit        src_burst = 1'b0;
	bit        sink_burst = 1'b0;
	bit        steady = 1'b0;
	int        mismatches = 0;
	int        idle_cycles = 0;

	stepper_axis_dda_with_homing dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void load_error(input longint minor, input longint major);
		ax_minor = minor;
		ax_major = major;
		ax_error = minor - major;
		ax_step_out = 1'b0;
	endfunction

	function automatic stad_pkg::out_beat_t advance_axis(input command_t c);
		longint              span;
		longint              err_next;
		longint              acc;
		stad_pkg::out_beat_t r;
		case (c.kind)
			stad_pkg::KIND_SET_TARGET: begin
				span = longint'($signed(c.ops.target_position)) - longint'(ax_position);
				if (span < 0) begin
					ax_direction = 1'b0;
					span = -span;
				end else begin
					ax_direction = 1'b1;
				end
				if (span > longint'(stad_pkg::SAT31))
					span = longint'(stad_pkg::SAT31);
				ax_pending = span[30:0];
			end
			stad_pkg::KIND_START_MOVE: begin
				ax_dir_out = ax_direction ^ cfg_inverse_dir;
				load_error(longint'(ax_pending), longint'(c.ops.major_steps));
			end
			stad_pkg::KIND_SET_STEPS: begin
				ax_direction = c.ops.move_dir;
				ax_dir_out = c.ops.move_dir;
				load_error(longint'(c.ops.step_count), longint'(c.ops.major_steps));
			end
			stad_pkg::KIND_TICK_ON: begin
				if (ax_error < 0) begin
					err_next = ax_error + 2 * ax_minor;
				end else begin
					ax_step_out = 1'b1;
					ax_position = ax_direction ? ax_position + 1 : ax_position - 1;
					err_next = ax_error + 2 * (ax_minor - ax_major);
				end
				if (err_next > longint'(stad_pkg::ERR_MAX))
					err_next = longint'(stad_pkg::ERR_MAX);
				ax_error = err_next;
			end
			stad_pkg::KIND_TICK_OFF: begin
				ax_step_out = 1'b0;
			end
			stad_pkg::KIND_START_HOME: begin
				if (c.ops.home_switch) begin
					ax_home_found = 1'b1;
				end else begin
					ax_home_timer = '0;
					ax_home_found = 1'b0;
					ax_dir_out = cfg_home_dir;
					ax_home_phase = 1'b0;
				end
			end
			stad_pkg::KIND_HOME_TICK: begin
				if (!ax_home_found) begin
					acc = longint'(ax_home_timer) + longint'(c.ops.elapsed);
					if (acc > 64'hFFFF_FFFF)
						acc = 64'hFFFF_FFFF;
					ax_home_timer = acc[31:0];
					if (ax_home_timer > 32'(cfg_home_delay)) begin
						ax_home_timer = ax_home_timer - 32'(cfg_home_delay);
						if (ax_home_phase) begin
							ax_step_out = 1'b1;
						end else begin
							ax_step_out = 1'b0;
							if (c.ops.home_switch)
								ax_home_found = 1'b1;
						end
						ax_home_phase = !ax_home_phase;
					end
				end
			end
			default: ;
		endcase
		r.pad = '0;
		r.step_level = ax_step_out;
		r.dir_level = ax_dir_out;
		r.position_now = ax_position;
		r.steps_to_do = ax_pending;
		r.homed = ax_home_found;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("ERROR %0t: %s expected %0d, got %0d", $realtime, what, want, got);
	endtask

	task automatic check_status(input stad_pkg::out_beat_t got);
		stad_pkg::out_beat_t want;
		if (status_queue.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("ERROR %0t: status beat %h with nothing expected", $realtime, got);
			return;
		end
		want = status_queue.pop_front();
		if (got.step_level !== want.step_level)
			note_mismatch("step_level", want.step_level, got.step_level);
		if (got.dir_level !== want.dir_level)
			note_mismatch("dir_level", want.dir_level, got.dir_level);
		if (got.position_now !== want.position_now)
			note_mismatch("position_now", longint'($signed(want.position_now)),
				longint'($signed(got.position_now)));
		if (got.steps_to_do !== want.steps_to_do)
			note_mismatch("steps_to_do", want.steps_to_do, got.steps_to_do);
		if (got.homed !== want.homed)
			note_mismatch("homed", want.homed, got.homed);
	endtask

	// command source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap <= 0;
		end else begin
			src_busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				status_queue.push_back(advance_axis(cmd_now));
				src_busy = 1'b0;
			end
			if (!src_busy) begin
				if (src_gap == 0 && cmd_queue.size() != 0) begin
					cmd_now = cmd_queue.pop_front();
					s_axis_tdata <= cmd_now.ops;
					s_axis_tuser <= cmd_now.kind;
					s_axis_tvalid <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						src_burst = !src_burst;
					src_gap <= (src_burst || steady) ? 0 : int'($urandom_range(0, 8));
				end else begin
					s_axis_tvalid <= 1'b0;
					if (src_gap != 0)
						src_gap <= src_gap - 1;
				end
			end
		end
	end

	// status sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			sink_wait = sink_gap;
			if (m_axis_tvalid && m_axis_tready) begin
				check_status(m_axis_tdata);
				if ($urandom_range(0, 39) == 0)
					sink_burst = !sink_burst;
				sink_wait = (sink_burst || steady) ? 0 : int'($urandom_range(0, 8));
			end
			if (sink_wait != 0) begin
				m_axis_tready <= 1'b0;
				sink_gap <= sink_wait - 1;
			end else begin
				m_axis_tready <= 1'b1;
				sink_gap <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic write_reg(input stad_pkg::cfg_reg_t idx,
		input logic [stad_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			stad_pkg::REG_INVERSE_DIR:     cfg_inverse_dir = value[0];
			stad_pkg::REG_HOME_DIR:        cfg_home_dir = value[0];
			stad_pkg::REG_HOME_STEP_DELAY: cfg_home_delay = value;
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_cmd(input command_t c);
		cmd_queue.push_back(c);
		queued_items++;
	endtask

	function automatic command_t build_cmd(input logic [2:0] k, input int tgt,
		input int cnt, input int mdir, input int maj, input int el, input int sw);
		command_t c;
		c.kind = k;
		c.ops.target_position = tgt;
		c.ops.step_count = 31'(cnt);
		c.ops.move_dir = mdir[0];
		c.ops.major_steps = 31'(maj);
		c.ops.elapsed = 16'(el);
		c.ops.home_switch = sw[0];
		return c;
	endfunction

	// random operands everywhere; the caller overrides what matters
	function automatic command_t any_cmd(input logic [2:0] k);
		logic [127:0] raw;
		command_t     c;
		raw = {$urandom, $urandom, $urandom, $urandom};
		c.kind = k;
		c.ops = raw[stad_pkg::S_TDATA_W-1:0];
		return c;
	endfunction

	task automatic settle();
		@(negedge clk);
		while (cmd_queue.size() != 0 || s_axis_tvalid || status_queue.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_part(input int amount, input logic [stad_pkg::CFG_DATA_W-1:0] delay);
		int       stop;
		int       n;
		int       major;
		int       lim;
		command_t c;
		stop = queued_items + amount;
		lim = (delay > 65533) ? 65535 : delay + 2;
		while (queued_items < stop) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					c = any_cmd(stad_pkg::KIND_SET_TARGET);
					if ($urandom_range(0, 7) != 0)
						c.ops.target_position = $urandom_range(0, 120) - 60;
					queue_cmd(c);
					c = any_cmd(stad_pkg::KIND_START_MOVE);
					if ($urandom_range(0, 7) != 0)
						c.ops.major_steps = 31'($urandom_range(0, 40));
					queue_cmd(c);
					n = $urandom_range(1, 30);
					repeat (n) begin
						queue_cmd(any_cmd(stad_pkg::KIND_TICK_ON));
						if ($urandom_range(0, 5) != 0)
							queue_cmd(any_cmd(stad_pkg::KIND_TICK_OFF));
					end
				end
				4, 5: begin
					major = $urandom_range(0, 30);
					c = any_cmd(stad_pkg::KIND_SET_STEPS);
					if ($urandom_range(0, 7) != 0) begin
						c.ops.major_steps = 31'(major);
						c.ops.step_count = 31'($urandom_range(0, major));
					end
					queue_cmd(c);
					n = major + $urandom_range(0, 3);
					repeat (n) begin
						queue_cmd(any_cmd(stad_pkg::KIND_TICK_ON));
						queue_cmd(any_cmd(stad_pkg::KIND_TICK_OFF));
					end
				end
				6, 7: begin
					c = any_cmd(stad_pkg::KIND_START_HOME);
					c.ops.home_switch = ($urandom_range(0, 5) == 0);
					queue_cmd(c);
					n = $urandom_range(3, 20);
					repeat (n) begin
						c = any_cmd(stad_pkg::KIND_HOME_TICK);
						c.ops.elapsed = 16'($urandom_range(0, lim));
						c.ops.home_switch = ($urandom_range(0, 3) == 0);
						queue_cmd(c);
					end
				end
				default: begin
					n = $urandom_range(1, 3);
					repeat (n) queue_cmd(any_cmd(3'($urandom_range(0, 7))));
				end
			endcase
		end
	endtask

	initial begin
		int                              phase;
		logic [stad_pkg::CFG_DATA_W-1:0] delay;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration: homing from reset state, unused kind, distance extremes
		queue_cmd(build_cmd(stad_pkg::KIND_HOME_TICK, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_HOME_TICK, 0, 0, 0, 0, 'hFFFF, 1));
		queue_cmd(build_cmd(stad_pkg::KIND_START_HOME, 0, 0, 0, 0, 0, 1));
		queue_cmd(build_cmd(KIND_UNUSED, -1, 'h7FFF_FFFF, 1, 'h7FFF_FFFF, 'hFFFF, 1));
		queue_cmd(build_cmd(stad_pkg::KIND_SET_TARGET, 'h7FFF_FFFF, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_START_MOVE, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_ON, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_ON, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_OFF, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_SET_TARGET, 'h8000_0000, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_SET_STEPS, 0, 'h7FFF_FFFF, 1, 'h7FFF_FFFF, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_ON, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_OFF, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_SET_STEPS, 0, 0, 0, 3, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_ON, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_ON, 0, 0, 0, 0, 0, 0));
		settle();

		// inverted direction, short homing period, switch found on a low phase
		write_reg(stad_pkg::REG_INVERSE_DIR, 20'd1);
		write_reg(stad_pkg::REG_HOME_DIR, 20'd1);
		write_reg(stad_pkg::REG_HOME_STEP_DELAY, 20'd3);
		queue_cmd(build_cmd(stad_pkg::KIND_SET_TARGET, -5, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_START_MOVE, 0, 0, 0, 8, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_ON, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_TICK_OFF, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_START_HOME, 0, 0, 0, 0, 0, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_HOME_TICK, 0, 0, 0, 0, 4, 0));
		queue_cmd(build_cmd(stad_pkg::KIND_HOME_TICK, 0, 0, 0, 0, 4, 1));
		queue_cmd(build_cmd(stad_pkg::KIND_HOME_TICK, 0, 0, 0, 0, 2, 1));
		queue_cmd(build_cmd(stad_pkg::KIND_HOME_TICK, 0, 0, 0, 0, 'hFFFF, 0));
		settle();

		// pile up homing time with a zero period, then drain it with the longest period
		write_reg(stad_pkg::REG_HOME_STEP_DELAY, 20'd0);
		steady = 1'b1;
		queue_cmd(build_cmd(stad_pkg::KIND_START_HOME, 0, 0, 0, 0, 0, 0));
		repeat (24) queue_cmd(build_cmd(stad_pkg::KIND_HOME_TICK, 0, 0, 0, 0, 'hFFFF, 0));
		settle();
		steady = 1'b0;
		write_reg(stad_pkg::REG_HOME_STEP_DELAY, 20'hF_FFFF);
		repeat (24) queue_cmd(build_cmd(stad_pkg::KIND_HOME_TICK, 0, 0, 0, 0, 0, 0));
		settle();

		for (phase = 0; phase < 7; phase++) begin
			case (phase)
				0:       delay = '0;
				1:       delay = 20'hF_FFFF;
				default: delay = 20'($urandom_range(1, 300));
			endcase
			write_reg(stad_pkg::REG_INVERSE_DIR, 20'(phase[0]));
			write_reg(stad_pkg::REG_HOME_DIR, 20'(phase[1]));
			write_reg(stad_pkg::REG_HOME_STEP_DELAY, delay);
			random_part(80, delay);
			settle();
		end

		repeat (10) @(posedge clk);
		mismatches += status_queue.size();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
rtl/stad_pkg.sv
rtl/stepper_axis_dda_with_homing.sv
rtl/stad_checker.sv
tb/stepper_axis_dda_with_homing_tb.sv
